/* design/repeated_word_detector_defines.svh */
// Assertion macros shared by the repeated word detector RTL.
`ifndef REPEATED_WORD_DETECTOR_DEFINES_SVH
`define REPEATED_WORD_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Concurrent check on clk, off while rst_n is low.
`define RWD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rwd: check failed");

// Condition that must never hold.
`define RWD_NEVER(lbl, expr) \
  `RWD_ASSERT(lbl, !(expr))

`else

`define RWD_ASSERT(lbl, prop)
`define RWD_NEVER(lbl, expr)

`endif

`endif

/* design/rwd_pkg.sv */
// Shared constants, types and helpers of the repeated word detector.
`default_nettype none

package rwd_pkg;

  localparam int unsigned WORD_CHARS_DEF  = 63;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LINE_W = 24;

  localparam logic [LINE_W-1:0] LINE_FIRST = LINE_W'(1);
  localparam logic [LINE_W-1:0] LINE_MAX   = '1;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_SPACE,
    KIND_NEWLINE,
    KIND_EOT
  } kind_t;

  // One classified beat on its way from front to back.
  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic              letter;
  } item_t;

  function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c | CASE_BIT;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/rwd_ifs.sv */
// Channel interfaces of the repeated word detector.
`default_nettype none

interface rwd_in_if;
  import rwd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_text;
  modport source(output valid, char_code, end_of_text, input ready);
  modport sink(input valid, char_code, end_of_text, output ready);
endinterface

interface rwd_out_if;
  import rwd_pkg::*;
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_number;
  logic [CHAR_W-1:0] word_char;
  logic              last_char;
  modport source(output valid, line_number, word_char, last_char, input ready);
  modport sink(input valid, line_number, word_char, last_char, output ready);
endinterface

`default_nettype wire

/* design/rwd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents when both ports hit one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* design/rwd_front.sv */
// Front end: takes input beats and classifies each byte.
`default_nettype none

module rwd_front (
  rwd_in_if.sink                in_bus,
  output rwd_pkg::item_t        item,
  output logic                  item_valid,
  input  wire logic             item_ready
);

  import rwd_pkg::*;

  logic              is_space;
  logic [CHAR_W-1:0] folded;

  assign is_space = (in_bus.char_code == CH_SPACE) ||
                    ((in_bus.char_code >= CH_TAB) && (in_bus.char_code <= CH_CR));
  assign folded   = fold_lower(in_bus.char_code);

  always_comb begin
    item.ch     = folded;
    item.letter = (folded >= CH_LO_A) && (folded <= CH_LO_Z);
    priority if (in_bus.end_of_text) begin
      item.kind = KIND_EOT;
    end else if (in_bus.char_code == CH_NL) begin
      item.kind = KIND_NEWLINE;
    end else if (is_space) begin
      item.kind = KIND_SPACE;
    end else begin
      item.kind = KIND_CHAR;
    end
  end

  assign item_valid   = in_bus.valid;
  assign in_bus.ready = item_ready;

endmodule

`default_nettype wire

/* design/rwd_fifo.sv */
// Short queue of classified beats between front and back end.
`default_nettype none

module rwd_fifo #(
  parameter int unsigned DEPTH = rwd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  rwd_pkg::item_t      push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output rwd_pkg::item_t      pop_item
);

  import rwd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            slot_r [DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[head_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
    end
    if (do_pop) begin
      head_nxt = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
    if (do_push) begin
      slot_r[tail_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* design/rwd_back.sv */
// Back end: word store, comparison against the previous word, report sequencer.
`default_nettype none

`include "repeated_word_detector_defines.svh"

module rwd_back #(
  parameter int unsigned WORD_CHARS = rwd_pkg::WORD_CHARS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  output logic           q_ready,
  input  rwd_pkg::item_t q_item,
  rwd_out_if.source      out_bus
);

  import rwd_pkg::*;

  localparam int unsigned LEN_W  = $clog2(WORD_CHARS + 1);
  localparam int unsigned ADDR_W = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;

  typedef enum logic {
    S_RUN,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  cur_len_r, cur_len_nxt;
  logic [LEN_W-1:0]  prev_len_r, prev_len_nxt;
  logic              in_word_r, in_word_nxt;
  logic              match_r, match_nxt;
  logic              run_rep_r, run_rep_nxt;
  logic              line_dummy;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic              pend_in_prev_r, pend_in_prev_nxt;
  logic [CHAR_W-1:0] pend_ch_r, pend_ch_nxt;
  logic              first_letter_r, first_letter_nxt;
  logic [LEN_W-1:0]  rep_len_r, rep_len_nxt;
  logic [LINE_W-1:0] rep_line_r, rep_line_nxt;
  logic [LEN_W-1:0]  emit_pos_r, emit_pos_nxt;
  logic              out_v_r, out_v_nxt;
  logic [LINE_W-1:0] out_line_r, out_line_nxt;
  logic [CHAR_W-1:0] out_ch_r, out_ch_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic              match_eff;
  logic              out_free;
  logic              is_repeat;
  logic              emit_last;
  logic [LEN_W-1:0]  char_idx;
  logic [LEN_W-1:0]  emit_next;

  rwd_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (WORD_CHARS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_item.ch),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Byte compare comes in the cycle after the store write (registered read).
  assign match_eff = match_r &&
                     (!pend_v_r || (pend_in_prev_r && (ram_rdata == pend_ch_r)));
  assign is_repeat = (cur_len_r != '0) && (cur_len_r == prev_len_r) &&
                     match_eff && first_letter_r;
  assign q_ready   = (state_r == S_RUN);
  assign out_free  = !out_v_r || out_bus.ready;
  assign char_idx  = in_word_r ? cur_len_r : '0;
  assign emit_next = emit_pos_r + LEN_W'(1);
  assign emit_last = (emit_next == rep_len_r);
  assign line_dummy = 1'b0;

  always_comb begin
    state_nxt        = state_r;
    cur_len_nxt      = cur_len_r;
    prev_len_nxt     = prev_len_r;
    in_word_nxt      = in_word_r;
    match_nxt        = match_eff;
    run_rep_nxt      = run_rep_r;
    line_nxt         = line_r;
    pend_v_nxt       = 1'b0;
    pend_in_prev_nxt = pend_in_prev_r;
    pend_ch_nxt      = pend_ch_r;
    first_letter_nxt = first_letter_r;
    rep_len_nxt      = rep_len_r;
    rep_line_nxt     = rep_line_r;
    emit_pos_nxt     = emit_pos_r;
    out_v_nxt        = out_v_r && !out_bus.ready;
    out_line_nxt     = out_line_r;
    out_ch_nxt       = out_ch_r;
    out_last_nxt     = out_last_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = char_idx[ADDR_W-1:0];
    ram_raddr        = char_idx[ADDR_W-1:0];

    unique case (state_r)
      S_RUN: begin
        if (q_valid) begin
          unique case (q_item.kind)
            KIND_CHAR: begin
              in_word_nxt = 1'b1;
              if (!in_word_r) begin
                match_nxt        = 1'b1;
                first_letter_nxt = q_item.letter;
              end
              if (char_idx < LEN_W'(WORD_CHARS)) begin
                ram_we           = 1'b1;
                ram_re           = 1'b1;
                pend_v_nxt       = 1'b1;
                pend_ch_nxt      = q_item.ch;
                pend_in_prev_nxt = (char_idx < prev_len_r);
                cur_len_nxt      = char_idx + LEN_W'(1);
              end
            end
            KIND_SPACE, KIND_NEWLINE, KIND_EOT: begin
              if (in_word_r) begin
                prev_len_nxt = cur_len_r;
                cur_len_nxt  = '0;
                in_word_nxt  = 1'b0;
                match_nxt    = 1'b0;
                run_rep_nxt  = is_repeat;
                if (is_repeat && !run_rep_r) begin
                  // First repeat of a run: start reading the word back at byte 0.
                  state_nxt    = S_EMIT;
                  rep_len_nxt  = cur_len_r;
                  rep_line_nxt = line_r;
                  emit_pos_nxt = '0;
                  ram_re       = 1'b1;
                  ram_raddr    = '0;
                end
              end
              if (q_item.kind == KIND_NEWLINE && line_r != LINE_MAX) begin
                line_nxt = line_r + LINE_W'(1);
              end
            end
            default: begin
              line_nxt = line_r;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_line_nxt = rep_line_r;
          out_ch_nxt   = ram_rdata;
          out_last_nxt = emit_last;
          if (emit_last) begin
            state_nxt = S_RUN;
          end else begin
            ram_re       = 1'b1;
            ram_raddr    = emit_next[ADDR_W-1:0];
            emit_pos_nxt = emit_next;
          end
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_RUN;
      cur_len_r  <= '0;
      prev_len_r <= '0;
      in_word_r  <= 1'b0;
      match_r    <= 1'b0;
      run_rep_r  <= 1'b0;
      line_r     <= LINE_FIRST;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_len_r  <= cur_len_nxt;
      prev_len_r <= prev_len_nxt;
      in_word_r  <= in_word_nxt;
      match_r    <= match_nxt;
      run_rep_r  <= run_rep_nxt;
      line_r     <= line_nxt | LINE_W'(line_dummy);
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
    end
    pend_in_prev_r <= pend_in_prev_nxt;
    pend_ch_r      <= pend_ch_nxt;
    first_letter_r <= first_letter_nxt;
    rep_len_r      <= rep_len_nxt;
    rep_line_r     <= rep_line_nxt;
    emit_pos_r     <= emit_pos_nxt;
    out_line_r     <= out_line_nxt;
    out_ch_r       <= out_ch_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_bus.valid       = out_v_r;
  assign out_bus.line_number = out_line_r;
  assign out_bus.word_char   = out_ch_r;
  assign out_bus.last_char   = out_last_r;

  `RWD_NEVER(a_len_bound, cur_len_r > LEN_W'(WORD_CHARS))
  `RWD_ASSERT(a_closed_empty, !in_word_r |-> cur_len_r == '0)
  `RWD_ASSERT(a_report_run, $rose(state_r == S_EMIT) |-> run_rep_r && rep_len_r == prev_len_r)
  `RWD_ASSERT(a_last_ends, (state_r == S_EMIT && out_free && emit_last) |=> (state_r == S_RUN && out_v_r && out_last_r))

endmodule

`default_nettype wire

/* design/repeated_word_detector.sv */
// Top level of the repeated word detector.
`default_nettype none

// Repeated word detector. Text enters one byte per beat on in_bus; a beat with
// end_of_text set closes any open word and its byte is ignored. Words are runs
// of non-whitespace bytes (tab through carriage return, and space), folded to
// lower case, of which only the first WORD_CHARS bytes are kept and compared.
// When a word that starts with a letter equals the previous word, and no report
// stands yet for that run of repeats, the word is sent on out_bus one byte per
// beat with the line on which it ends (first line is 1, saturating at 2^24-1);
// last_char marks its final byte. Later copies in the same run are silent.
// Structure: a front end classifies each byte, a QUEUE_DEPTH-entry queue
// decouples it from the back end, and the back end keeps the current word in
// a WORD_CHARS-entry store, compares each new byte against the previous word as
// it overwrites it, and reads a reported word back out. Rate: one input byte
// per cycle in steady state. A reported word holds the back end while it is
// read back one byte a cycle, output stalls apart, over the store's single
// read port; the queue absorbs input meanwhile, after which in_bus.ready
// drops. With an empty queue, the closing byte is registered in the queue and
// taken by the back end, which enters S_EMIT and reads store byte 0; that byte
// is registered on out_bus, raising out_bus.valid. The store needs no clearing
// after reset: only entries written for the current or previous word are used.
module repeated_word_detector #(
  parameter int unsigned WORD_CHARS  = rwd_pkg::WORD_CHARS_DEF,
  parameter int unsigned QUEUE_DEPTH = rwd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rwd_in_if.sink     in_bus,
  rwd_out_if.source  out_bus
);

  import rwd_pkg::*;

  // Front to queue.
  item_t front_item;
  logic  front_valid;
  logic  front_ready;

  // Queue to back end.
  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  rwd_front u_front (
    .in_bus     (in_bus),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  rwd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Back end owns the word store and the report sequencer.
  rwd_back #(
    .WORD_CHARS (WORD_CHARS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire
